### src/mpe_pkg.sv
// Package for the MessagePack value encoder: kind codes, format bytes and the encoded-item type.
package mpe_pkg;

    // Kind codes carried on the input channel.
    localparam logic [2:0] KIND_BOOL   = 3'd0;
    localparam logic [2:0] KIND_INT    = 3'd1;
    localparam logic [2:0] KIND_FLT32  = 3'd2;
    localparam logic [2:0] KIND_FLT64  = 3'd3;
    localparam logic [2:0] KIND_STR    = 3'd4;
    localparam logic [2:0] KIND_MAP    = 3'd5;
    localparam logic [2:0] KIND_ARRAY  = 3'd6;
    localparam logic [2:0] KIND_RAW    = 3'd7;

    // MessagePack format bytes.
    localparam logic [7:0] FMT_FALSE    = 8'hc2;
    localparam logic [7:0] FMT_TRUE     = 8'hc3;
    localparam logic [7:0] FMT_FLT32    = 8'hca;
    localparam logic [7:0] FMT_FLT64    = 8'hcb;
    localparam logic [7:0] FMT_UINT8    = 8'hcc;
    localparam logic [7:0] FMT_UINT16   = 8'hcd;
    localparam logic [7:0] FMT_UINT32   = 8'hce;
    localparam logic [7:0] FMT_UINT64   = 8'hcf;
    localparam logic [7:0] FMT_INT8     = 8'hd0;
    localparam logic [7:0] FMT_INT16    = 8'hd1;
    localparam logic [7:0] FMT_INT32    = 8'hd2;
    localparam logic [7:0] FMT_INT64    = 8'hd3;
    localparam logic [7:0] FMT_STR8     = 8'hd9;
    localparam logic [7:0] FMT_STR16    = 8'hda;
    localparam logic [7:0] FMT_STR32    = 8'hdb;
    localparam logic [7:0] FMT_ARRAY16  = 8'hdc;
    localparam logic [7:0] FMT_ARRAY32  = 8'hdd;
    localparam logic [7:0] FMT_MAP16    = 8'hde;
    localparam logic [7:0] FMT_MAP32    = 8'hdf;
    localparam logic [7:0] FMT_FIXSTR   = 8'ha0;
    localparam logic [7:0] FMT_FIXMAP   = 8'h80;
    localparam logic [7:0] FMT_FIXARRAY = 8'h90;

    // One encoded item: the leading byte, the trailing bytes packed from the
    // top of the word, and how many trailing bytes follow (0 to 8).
    typedef struct packed {
        logic [7:0]  head;
        logic [63:0] body;
        logic [3:0]  nbytes;
    } enc_t;

endpackage

### src/msgpack_value_encoder_unit.sv
// Top level of the MessagePack value encoder: input register, encoder and byte serializer.
//
//   Channel | Handshake            | Payload
//   --------+----------------------+------------------------------
//   input   | in_valid / in_ready  | kind[2:0], value[63:0]
//   output  | out_valid / out_ready| out_byte[7:0], last
//
// An accepted item waits in the input register until the serializer can take
// it, is encoded by a short block of compares and a byte mux, and is loaded
// into the serializer's frame register, which drives the first byte out.
// Each item occupies the output for its head byte and n trailing bytes, where
// n is 0, 1, 2, 4 or 8 as set by its MessagePack form; single-byte items flow
// at one item per cycle while out_ready is held high. While a multi-byte item
// drains, the input register takes one more item and in_ready then stays low
// until the last byte is taken.
// Reset clears only the valid flags and the byte count; the data registers
// carry no reset. A stalled output freezes the serializer and a full input
// register.
module msgpack_value_encoder_unit
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [2:0]  kind,
    input  logic [63:0] value,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [7:0]  out_byte,
    output logic        last
);

    // Input register: one item deep, emptied whenever the serializer can
    // take a new frame.
    logic          in_vld_reg;
    logic          in_vld_next;
    logic [2:0]    kind_reg;
    logic [63:0]   value_reg;
    logic          ser_ready;
    mpe_pkg::enc_t enc;

    // The input slot frees when its item moves into the serializer in the
    // same cycle, so single-byte items stream without a bubble.
    assign in_ready = !in_vld_reg || ser_ready;

    always_comb
    begin
        in_vld_next = in_vld_reg;
        if (in_ready)
        begin
            in_vld_next = in_valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg <= 1'b0;
        end
        else
        begin
            in_vld_reg <= in_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready)
        begin
            kind_reg  <= kind;
            value_reg <= value;
        end
    end

    // Pick the MessagePack form and lay out the bytes of the frame.
    mpe_encode u_encode
    (
        .kind  (kind_reg),
        .value (value_reg),
        .enc   (enc)
    );

    // Holds the frame and hands out one byte per accepted output item,
    // marking the final one.
    mpe_serializer u_serializer
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .load_valid (in_vld_reg),
        .load_ready (ser_ready),
        .enc        (enc),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_byte   (out_byte),
        .last       (last)
    );

endmodule

### src/mpe_encode.sv
// Combinational encoder: turns one kind/value pair into its MessagePack byte frame.
module mpe_encode
(
    input  logic [2:0]   kind,
    input  logic [63:0]  value,
    output mpe_pkg::enc_t enc
);

    logic signed [63:0] sval;
    logic [7:0]         head;
    logic [3:0]         nbytes;

    assign sval = $signed(value);

    always_comb
    begin
        head   = mpe_pkg::FMT_FALSE;
        nbytes = 4'd0;
        unique case (kind) inside
            mpe_pkg::KIND_BOOL:
            begin
                head = (value != 64'd0) ? mpe_pkg::FMT_TRUE : mpe_pkg::FMT_FALSE;
            end
            mpe_pkg::KIND_INT:
            begin
                if (sval < -64'sd2147483648)
                begin
                    head   = mpe_pkg::FMT_INT64;
                    nbytes = 4'd8;
                end
                else if (sval < -64'sd32768)
                begin
                    head   = mpe_pkg::FMT_INT32;
                    nbytes = 4'd4;
                end
                else if (sval < -64'sd128)
                begin
                    head   = mpe_pkg::FMT_INT16;
                    nbytes = 4'd2;
                end
                else if (sval < -64'sd32)
                begin
                    head   = mpe_pkg::FMT_INT8;
                    nbytes = 4'd1;
                end
                else if (sval < 64'sd128)
                begin
                    head = value[7:0];
                end
                else if (sval < 64'sd256)
                begin
                    head   = mpe_pkg::FMT_UINT8;
                    nbytes = 4'd1;
                end
                else if (sval < 64'sd65536)
                begin
                    head   = mpe_pkg::FMT_UINT16;
                    nbytes = 4'd2;
                end
                else if (sval < 64'sd4294967296)
                begin
                    head   = mpe_pkg::FMT_UINT32;
                    nbytes = 4'd4;
                end
                else
                begin
                    head   = mpe_pkg::FMT_UINT64;
                    nbytes = 4'd8;
                end
            end
            mpe_pkg::KIND_FLT32:
            begin
                head   = mpe_pkg::FMT_FLT32;
                nbytes = 4'd4;
            end
            mpe_pkg::KIND_FLT64:
            begin
                head   = mpe_pkg::FMT_FLT64;
                nbytes = 4'd8;
            end
            mpe_pkg::KIND_STR:
            begin
                if (value < 64'd32)
                begin
                    head = mpe_pkg::FMT_FIXSTR | value[7:0];
                end
                else if (value < 64'd256)
                begin
                    head   = mpe_pkg::FMT_STR8;
                    nbytes = 4'd1;
                end
                else if (value < 64'd65536)
                begin
                    head   = mpe_pkg::FMT_STR16;
                    nbytes = 4'd2;
                end
                else
                begin
                    head   = mpe_pkg::FMT_STR32;
                    nbytes = 4'd4;
                end
            end
            mpe_pkg::KIND_MAP, mpe_pkg::KIND_ARRAY:
            begin
                if (value < 64'd16)
                begin
                    head = ((kind == mpe_pkg::KIND_MAP) ? mpe_pkg::FMT_FIXMAP
                                                        : mpe_pkg::FMT_FIXARRAY)
                           | value[7:0];
                end
                else if (value < 64'd65536)
                begin
                    head   = (kind == mpe_pkg::KIND_MAP) ? mpe_pkg::FMT_MAP16
                                                         : mpe_pkg::FMT_ARRAY16;
                    nbytes = 4'd2;
                end
                else
                begin
                    head   = (kind == mpe_pkg::KIND_MAP) ? mpe_pkg::FMT_MAP32
                                                         : mpe_pkg::FMT_ARRAY32;
                    nbytes = 4'd4;
                end
            end
            default:
            begin
                head = value[7:0];
            end
        endcase
    end

    // Trailing bytes are the low nbytes of the operand, packed to the top.
    always_comb
    begin
        enc.head   = head;
        enc.nbytes = nbytes;
        case (nbytes)
            4'd1:    enc.body = {value[7:0],  56'd0};
            4'd2:    enc.body = {value[15:0], 48'd0};
            4'd4:    enc.body = {value[31:0], 32'd0};
            4'd8:    enc.body = value;
            default: enc.body = 64'd0;
        endcase
    end

endmodule

### src/mpe_serializer.sv
// Output stage: holds one encoded frame and shifts it out a byte at a time.
module mpe_serializer
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          load_valid,
    output logic          load_ready,
    input  mpe_pkg::enc_t enc,
    output logic          out_valid,
    input  logic          out_ready,
    output logic [7:0]    out_byte,
    output logic          last
);

    logic [71:0] frame_reg;
    logic [71:0] frame_next;
    logic [3:0]  rem_reg;
    logic [3:0]  rem_next;
    logic        valid_reg;
    logic        valid_next;
    logic        take;

    assign take       = valid_reg && out_ready;
    assign load_ready = !valid_reg || (take && (rem_reg == 4'd0));

    always_comb
    begin
        frame_next = frame_reg;
        rem_next   = rem_reg;
        valid_next = valid_reg;
        if (load_ready)
        begin
            frame_next = {enc.head, enc.body};
            rem_next   = enc.nbytes;
            valid_next = load_valid;
        end
        else if (take)
        begin
            frame_next = {frame_reg[63:0], 8'd0};
            rem_next   = rem_reg - 4'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            rem_reg   <= 4'd0;
        end
        else
        begin
            valid_reg <= valid_next;
            rem_reg   <= rem_next;
        end
    end

    always_ff @(posedge clk)
    begin
        frame_reg <= frame_next;
    end

    assign out_valid = valid_reg;
    assign out_byte  = frame_reg[71:64];
    assign last      = (rem_reg == 4'd0);

endmodule

### src/mpe_checker.sv
// Port-level checker for the MessagePack value encoder, bound to the top level.
module mpe_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_ready,
    input logic [7:0]  out_byte,
    input logic        last
);

    // Bytes delivered so far in the current run.
    logic [3:0] run_cnt_reg;
    logic [3:0] run_cnt_next;

    always_comb
    begin
        run_cnt_next = run_cnt_reg;
        if (out_valid && out_ready)
        begin
            run_cnt_next = last ? 4'd0 : (run_cnt_reg + 4'd1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_cnt_reg <= 4'd0;
        end
        else
        begin
            run_cnt_reg <= run_cnt_next;
        end
    end

    // A stalled output byte is held.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_byte) && $stable(last))
        else $error("output byte changed while stalled");

    // Within one item, out_valid stays high after each non-last byte is taken.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && !last |=> out_valid)
        else $error("gap inside a multi-byte item");

    // No item is longer than nine bytes.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (run_cnt_reg == 4'd8) |-> last)
        else $error("item ran past nine bytes");

    // Nothing is shown on the output straight after reset.
    assert property (@(posedge clk)
        $rose(rst_n) |-> !out_valid)
        else $error("output valid straight after reset");

endmodule

bind msgpack_value_encoder_unit mpe_checker u_mpe_checker
(
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_byte  (out_byte),
    .last      (last)
);
